/* src/rcp_pkg.sv */
// Shared types and constants for the RC pulse capture and scaling block.
`timescale 1ns / 1ps
package rcp_pkg;
    localparam int CHANNELS = 5;
    localparam int CH_W     = 3;
    localparam int CAL_W    = 49;
    localparam int VAL_W    = 11;
    localparam int WID_W    = 16;
    localparam int TIME_W   = 32;
    localparam int QUOT_W   = 9;
    localparam int NUM_W    = 25;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;
    localparam int MID      = 1500;
    localparam int SPAN     = 500;
    localparam int CMD_MIN  = 1000;
    localparam int CMD_MAX  = 2000;

    localparam logic [CAL_W-1:0] CAL_RESET = 49'h0_07D0_05DC_03E8;

    typedef logic [CAL_W-1:0] cal_t;
    typedef cal_t [CHANNELS-1:0] cal_arr_t;
    typedef logic [CH_W-1:0] ch_idx_t;

    typedef struct packed {
        logic    capture;
        logic    setup;
        logic    step;
        logic    store;
        logic    publish;
        ch_idx_t ch;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;
endpackage

/* src/rcp_in_if.sv */
// Input sample channel: pin levels and timestamp.
`timescale 1ns / 1ps
interface rcp_in_if;
    logic                      valid;
    logic                      ready;
    logic [rcp_pkg::CHANNELS-1:0] pin_levels;
    logic [rcp_pkg::TIME_W-1:0]   time_us;

    modport source (output valid, output pin_levels, output time_us, input ready);
    modport sink (input valid, input pin_levels, input time_us, output ready);
endinterface

/* src/rcp_out_if.sv */
// Result channel: scaled channel commands and capture mask.
`timescale 1ns / 1ps
interface rcp_out_if;
    logic                         valid;
    logic                         ready;
    logic [rcp_pkg::VAL_W-1:0]    ch1_value;
    logic [rcp_pkg::VAL_W-1:0]    ch2_value;
    logic [rcp_pkg::VAL_W-1:0]    ch3_value;
    logic [rcp_pkg::VAL_W-1:0]    ch4_value;
    logic [rcp_pkg::VAL_W-1:0]    ch5_value;
    logic [rcp_pkg::CHANNELS-1:0] captured_mask;

    modport source (output valid, output ch1_value, output ch2_value, output ch3_value,
                    output ch4_value, output ch5_value, output captured_mask, input ready);
    modport sink (input valid, input ch1_value, input ch2_value, input ch3_value,
                  input ch4_value, input ch5_value, input captured_mask, output ready);
endinterface

/* src/rcp_ctrl.sv */
// Sequencer: capture, per-channel setup, divide and store, then publish.
`timescale 1ns / 1ps
module rcp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rcp_pkg::sts_t sts,
    output rcp_pkg::cmd_t cmd
);
    import rcp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_PUB   = 3'd4;
    localparam logic [3:0] LAST_STEP = 4'(QUOT_W - 1);
    localparam ch_idx_t    LAST_CH   = CH_W'(CHANNELS - 1);

    logic [2:0] state_reg, state_next;
    ch_idx_t    ch_reg, ch_next;
    logic [3:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    ch_next     = '0;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == LAST_STEP)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if (ch_reg == LAST_CH)
                    state_next = S_PUB;
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_PUB:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= LAST_STEP) else $error("divide step overrun");
    a_ch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ch_reg <= LAST_CH) else $error("channel index out of range");
    a_store_then: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store && ch_reg != LAST_CH |=> cmd.setup) else $error("store not followed by setup");
`endif
endmodule

/* src/rcp_dp.sv */
// Datapath: edge capture, width scaling with a serial divider, result register.
`timescale 1ns / 1ps
module rcp_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcp_pkg::cmd_t                 cmd,
    output rcp_pkg::sts_t                 sts,
    input  rcp_pkg::cal_arr_t             cal,
    input  logic [rcp_pkg::CHANNELS-1:0]  pin_levels,
    input  logic [rcp_pkg::TIME_W-1:0]    time_us,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [rcp_pkg::VAL_W-1:0]     out_vals [rcp_pkg::CHANNELS],
    output logic [rcp_pkg::CHANNELS-1:0]  out_mask
);
    import rcp_pkg::*;

    logic [CHANNELS-1:0] prev_reg;
    logic [TIME_W-1:0]   rise_reg [CHANNELS];
    logic [WID_W-1:0]    pw_reg [CHANNELS];
    logic [CHANNELS-1:0] mask_reg;
    logic [VAL_W-1:0]    val_reg [CHANNELS];
    logic [NUM_W-1:0]    rem_reg, dsh_reg;
    logic [QUOT_W-1:0]   q_reg;
    logic                neg_reg, zero_reg;
    logic                ov_reg, ov_next;

    logic [WID_W-1:0] w, lo, ce, hi, xl, xh, a_abs, d_abs;
    logic             rev, lowside, highside;
    logic [WID_W:0]   a_s, d_s;
    logic [11:0]      sum;
    logic [VAL_W-1:0] val;

    assign sts.out_free = !ov_reg || out_ready;
    assign out_valid    = ov_reg;
    assign ov_next      = cmd.publish ? 1'b1 : (out_ready ? 1'b0 : ov_reg);

    always_comb
    begin
        w        = pw_reg[cmd.ch];
        lo       = cal[cmd.ch][15:0];
        ce       = cal[cmd.ch][31:16];
        hi       = cal[cmd.ch][47:32];
        rev      = cal[cmd.ch][48];
        lowside  = w < ce;
        highside = w > ce;
        xl       = (w < lo) ? lo : w;
        xh       = (w > hi) ? hi : w;
        a_s      = lowside ? ({1'b0, ce} - {1'b0, xl}) : ({1'b0, xh} - {1'b0, ce});
        d_s      = lowside ? ({1'b0, ce} - {1'b0, lo}) : ({1'b0, hi} - {1'b0, ce});
        a_abs    = a_s[WID_W] ? WID_W'(-a_s) : a_s[WID_W-1:0];
        d_abs    = d_s[WID_W] ? WID_W'(-d_s) : d_s[WID_W-1:0];
        sum      = neg_reg ? (12'(MID) - 12'(q_reg)) : (12'(MID) + 12'(q_reg));
        if (zero_reg)
            val = VAL_W'(MID);
        else if (sum < 12'(CMD_MIN))
            val = VAL_W'(CMD_MIN);
        else if (sum > 12'(CMD_MAX))
            val = VAL_W'(CMD_MAX);
        else
            val = sum[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            ov_reg   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                rise_reg[i] <= '0;
                pw_reg[i]   <= '0;
            end
        end
        else
        begin
            ov_reg <= ov_next;
            if (cmd.capture)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (pin_levels[i] && !prev_reg[i])
                    begin
                        prev_reg[i] <= 1'b1;
                        rise_reg[i] <= time_us;
                    end
                    else if (!pin_levels[i] && prev_reg[i])
                    begin
                        prev_reg[i] <= 1'b0;
                        pw_reg[i]   <= (|((time_us - rise_reg[i]) >> WID_W)) ? '1
                                       : WID_W'(time_us - rise_reg[i]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int i = 0; i < CHANNELS; i++)
                mask_reg[i] <= !pin_levels[i] && prev_reg[i];
        end
        if (cmd.setup)
        begin
            rem_reg  <= NUM_W'(a_abs) * NUM_W'(SPAN);
            dsh_reg  <= NUM_W'(d_abs) << (QUOT_W - 1);
            q_reg    <= '0;
            neg_reg  <= lowside ^ rev;
            zero_reg <= !(lowside || highside) || (d_s == '0);
        end
        if (cmd.step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[QUOT_W-2:0], 1'b1};
            end
            else
                q_reg <= {q_reg[QUOT_W-2:0], 1'b0};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.store)
            val_reg[cmd.ch] <= val;
        if (cmd.publish)
        begin
            out_vals <= val_reg;
            out_mask <= mask_reg;
        end
    end

`ifndef ASSERT_OFF
    a_pub_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> sts.out_free) else $error("result overwritten");
    a_quot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store && !zero_reg |-> q_reg <= QUOT_W'(SPAN)) else $error("quotient too large");
    a_cap_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !(cmd.setup || cmd.step || cmd.store || cmd.publish))
        else $error("capture during scaling");
`endif
endmodule

/* src/rc_pulse_capture_and_scaling.sv */
// Top level: APB calibration registers, sequencer and datapath.
//
// The edge at which an accepted sample is transferred also captures the pin
// edges. Then, for each of the five channels, there is a setup cycle, nine steps
// of a shared restoring divider and a store cycle; the serial divider is used
// once per channel. Once the result side is free, the result register is loaded
// and the sequencer returns to idle at the same edge, so no new sample is taken
// before the result of the previous one is loaded. A new sample is taken as soon
// as the sequencer is back in idle, even while the previous result still waits
// to be transferred. Calibration is written through APB (64-bit data, register n
// at byte address 8*n) and must only change while the block is idle.
`timescale 1ns / 1ps
module rc_pulse_capture_and_scaling (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rcp_pkg::ADDR_W-1:0]  paddr,
    input  logic [rcp_pkg::DATA_W-1:0]  pwdata,
    output logic [rcp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    rcp_in_if.sink                      in_ch,
    rcp_out_if.source                   out_ch
);
    import rcp_pkg::*;

    cal_arr_t         cal_reg;
    ch_idx_t          idx;
    cmd_t             cmd;
    sts_t             sts;
    logic [VAL_W-1:0] vals [CHANNELS];

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:3];
    assign prdata = (idx < CH_W'(CHANNELS)) ? DATA_W'(cal_reg[idx]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cal_reg <= {CHANNELS{CAL_RESET}};
        else if (psel && penable && pwrite && idx < CH_W'(CHANNELS))
            cal_reg[idx] <= pwdata[CAL_W-1:0];
    end

    rcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rcp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cal        (cal_reg),
        .pin_levels (in_ch.pin_levels),
        .time_us    (in_ch.time_us),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_vals   (vals),
        .out_mask   (out_ch.captured_mask)
    );

    assign out_ch.ch1_value = vals[0];
    assign out_ch.ch2_value = vals[1];
    assign out_ch.ch3_value = vals[2];
    assign out_ch.ch4_value = vals[3];
    assign out_ch.ch5_value = vals[4];
endmodule

/* bench/tb_top.sv */
// Self-checking bench for rc_pulse_capture_and_scaling: directed table, calibration corner cases, then random samples.
`timescale 1ns / 1ps
module tb_top;
    import rcp_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [CAL_W-1:0] CAL_ALL = {CAL_W{1'b1}};

    typedef struct packed {
        logic [CHANNELS-1:0]           mask;
        logic [CHANNELS-1:0][VAL_W-1:0] val;
    } cmd_frame_t;

    typedef struct {
        logic [CHANNELS-1:0] pins;
        logic [TIME_W-1:0]   t;
        bit                  typed;
        cmd_frame_t          frame;
    } sample_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    rcp_in_if  in_ch ();
    rcp_out_if out_ch ();

    rc_pulse_capture_and_scaling uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // predictor state
    cal_t                cal_model [CHANNELS];
    logic                level_q   [CHANNELS];
    logic [TIME_W-1:0]   rise_q    [CHANNELS];
    logic [WID_W-1:0]    width_q   [CHANNELS];
    cmd_frame_t          exp_cmds [$];

    int  errors = 0;
    int  cycles = 0;
    bit  calm = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    logic [TIME_W-1:0] now_us = '0;

    initial in_ch.valid = 1'b0;
    initial in_ch.pin_levels = '0;
    initial in_ch.time_us = '0;
    initial out_ch.ready = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] scale_cmd(logic [WID_W-1:0] width, cal_t c);
        longint lo;
        longint ce;
        longint hi;
        longint w;
        longint diff;
        longint den;
        longint r;
        bit     rev;
        lo  = c[15:0];
        ce  = c[31:16];
        hi  = c[47:32];
        rev = c[48];
        w   = width;
        if (w == ce)
            return VAL_W'(MID);
        if (w < ce)
        begin
            if (w < lo)
                w = lo;
            den = ce - lo;
            if (den == 0)
                return VAL_W'(MID);
            diff = ((ce - w) * SPAN) / den;
            r = rev ? MID + diff : MID - diff;
        end
        else
        begin
            if (w > hi)
                w = hi;
            den = hi - ce;
            if (den == 0)
                return VAL_W'(MID);
            diff = ((w - ce) * SPAN) / den;
            r = rev ? MID - diff : MID + diff;
        end
        if (r < CMD_MIN)
            r = CMD_MIN;
        if (r > CMD_MAX)
            r = CMD_MAX;
        return VAL_W'(r);
    endfunction

    function automatic cmd_frame_t capture_sample(logic [CHANNELS-1:0] pins,
                                                  logic [TIME_W-1:0] t);
        cmd_frame_t f;
        logic [TIME_W-1:0] d;
        f = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (pins[i])
            begin
                if (!level_q[i])
                begin
                    level_q[i] = 1'b1;
                    rise_q[i]  = t;
                end
            end
            else if (level_q[i])
            begin
                d = t - rise_q[i];
                level_q[i] = 1'b0;
                width_q[i] = (d > 32'hFFFF) ? 16'hFFFF : d[WID_W-1:0];
                f.mask[i] = 1'b1;
            end
        end
        for (int i = 0; i < CHANNELS; i++)
            f.val[i] = scale_cmd(width_q[i], cal_model[i]);
        return f;
    endfunction

    task automatic apb_write(int idx, cal_t value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * idx);
        pwdata  <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cal_model[idx] = value;
    endtask

    task automatic wait_idle();
        while (exp_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // drives one sample; leaves valid high after the transfer
    task automatic send_sample(logic [CHANNELS-1:0] pins, logic [TIME_W-1:0] t,
                               bit typed, cmd_frame_t typed_frame);
        cmd_frame_t f;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 21)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.pin_levels <= pins;
        in_ch.time_us    <= t;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        f = capture_sample(pins, t);
        exp_cmds.push_back(typed ? typed_frame : f);
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    function automatic cal_t random_cal();
        logic [15:0] lo;
        logic [15:0] ce;
        logic [15:0] hi;
        if ($urandom_range(0, 99) < 20)
            return cal_t'({$urandom, $urandom});
        lo = 16'($urandom_range(600, 1400));
        ce = lo + 16'($urandom_range(0, 800));
        hi = ce + 16'($urandom_range(0, 800));
        return {1'($urandom_range(0, 1)), hi, ce, lo};
    endfunction

    task automatic random_samples(int count);
        cmd_frame_t none;
        int r;
        none = '0;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                now_us = $urandom;
            else if (r < 8)
                now_us = now_us + $urandom_range(65000, 200000);
            else
                now_us = now_us + $urandom_range(1, 2600);
            send_sample(5'($urandom_range(0, 31)), now_us, 0, none);
        end
    endtask

    function automatic cmd_frame_t frame_of(int v1, int v2, int v3, int v4, int v5, int m);
        cmd_frame_t f;
        f.mask = 5'(m);
        f.val[0] = 11'(v1);
        f.val[1] = 11'(v2);
        f.val[2] = 11'(v3);
        f.val[3] = 11'(v4);
        f.val[4] = 11'(v5);
        return f;
    endfunction

    // result side: random stalls, one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 21);
    end

    always @(posedge clk)
    begin
        cmd_frame_t got;
        cmd_frame_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.mask   = out_ch.captured_mask;
            got.val[0] = out_ch.ch1_value;
            got.val[1] = out_ch.ch2_value;
            got.val[2] = out_ch.ch3_value;
            got.val[3] = out_ch.ch4_value;
            got.val[4] = out_ch.ch5_value;
            if (exp_cmds.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer mask=%h", got.mask);
            end
            else
            begin
                want = exp_cmds.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp mask=%h vals=%0d %0d %0d %0d %0d, got mask=%h vals=%0d %0d %0d %0d %0d",
                                 want.mask, want.val[0], want.val[1], want.val[2],
                                 want.val[3], want.val[4], got.mask, got.val[0],
                                 got.val[1], got.val[2], got.val[3], got.val[4]);
                end
            end
        end
    end

    initial
    begin
        sample_row_t rows [$];
        sample_row_t row;
        cmd_frame_t none;
        none = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            cal_model[i] = CAL_RESET;
            level_q[i] = 1'b0;
            rise_q[i]  = '0;
            width_q[i] = '0;
        end

        rows.push_back('{5'h00, 32'h0,        1, frame_of(1000, 1000, 1000, 1000, 1000, 0)});
        rows.push_back('{5'h1F, 32'd100,      1, frame_of(1000, 1000, 1000, 1000, 1000, 0)});
        rows.push_back('{5'h00, 32'd1600,     1, frame_of(1500, 1500, 1500, 1500, 1500, 5'h1F)});
        rows.push_back('{5'h1F, 32'd2000,     1, frame_of(1500, 1500, 1500, 1500, 1500, 0)});
        rows.push_back('{5'h00, 32'd4000,     1, frame_of(2000, 2000, 2000, 2000, 2000, 5'h1F)});
        rows.push_back('{5'h15, 32'hFFFFFFF0, 1, frame_of(2000, 2000, 2000, 2000, 2000, 0)});
        rows.push_back('{5'h00, 32'h10,       1, frame_of(1000, 2000, 1000, 2000, 1000, 5'h15)});
        rows.push_back('{5'h1F, 32'h100,      1, frame_of(1000, 2000, 1000, 2000, 1000, 0)});
        rows.push_back('{5'h00, 32'h20100,    1, frame_of(2000, 2000, 2000, 2000, 2000, 5'h1F)});
        rows.push_back('{5'h0A, 32'h20200,    0, none});
        rows.push_back('{5'h05, 32'h20900,    0, none});
        rows.push_back('{5'h00, 32'h21000,    0, none});
        rows.push_back('{5'h1F, 32'hFFFFFFFF, 0, none});
        rows.push_back('{5'h00, 32'h000005DB, 0, none});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[k])
        begin
            row = rows[k];
            send_sample(row.pins, row.t, row.typed, row.frame);
        end
        now_us = 32'h21000;
        stop_input();
        wait_idle();

        // zero denominators, reverse, inverted and all-zero calibration
        apb_write(0, {1'b0, 16'd2000, 16'd1500, 16'd1500});
        apb_write(1, {1'b0, 16'd1500, 16'd1500, 16'd1000});
        apb_write(2, {1'b1, 16'd2000, 16'd1500, 16'd1000});
        apb_write(3, {1'b0, 16'd1200, 16'd1500, 16'd1800});
        apb_write(4, '0);
        for (int n = 0; n < 10; n++)
        begin
            now_us = now_us + 32'd10;
            send_sample(5'h1F, now_us, 0, none);
            now_us = now_us + 32'($urandom_range(500, 2600));
            send_sample(5'h00, now_us, 0, none);
        end
        stop_input();
        wait_idle();

        for (int i = 0; i < CHANNELS; i++)
            apb_write(i, CAL_ALL);
        random_samples(60);
        stop_input();
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            for (int i = 0; i < CHANNELS; i++)
                apb_write(i, (ph == 5) ? CAL_RESET : random_cal());
            if (ph == 1)
                hold_req = 1;
            calm = (ph == 3);
            random_samples(140);
            calm = 0;
            stop_input();
            wait_idle();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
